### sv/octahedron_sphere_triangle_gen_core_defines.svh
// ----------------------------------------------------------------------------
// Octahedron sphere triangle generator: assertion macros
// Shared concurrent assertion forms, clocked on aclk and idle in reset.
// ----------------------------------------------------------------------------
`ifndef OCTAHEDRON_SPHERE_TRIANGLE_GEN_CORE_DEFINES_SVH
`define OCTAHEDRON_SPHERE_TRIANGLE_GEN_CORE_DEFINES_SVH

// Same-cycle implication.
`define OSTG_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication.
`define OSTG_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error(msg);

`endif

### sv/ostg_pkg.sv
// ----------------------------------------------------------------------------
// Octahedron sphere triangle generator package
// Beat types, pipeline stage types and the per-step arithmetic functions.
// ----------------------------------------------------------------------------
package ostg_pkg;

    localparam int MAX_LEVEL  = 7;
    localparam int FRAC_BITS  = 14;
    localparam int LVL_W      = 3;
    localparam int IDX_W      = 7;
    localparam int MAG_W      = MAX_LEVEL + 1;
    localparam int SQ_W       = 2 * MAG_W;
    localparam int LEN_W      = 2 * MAX_LEVEL + 1;
    localparam int COORD_W    = 16;
    localparam int DIV_STEPS  = 2 * FRAC_BITS + 3;
    localparam int SQRT_STEPS = (DIV_STEPS + 1) / 2;
    localparam int F_W        = 2 * SQRT_STEPS;
    localparam int ROOT_W     = SQRT_STEPS;
    localparam int RSQ_W      = ROOT_W + 2;
    localparam int REM_W      = LEN_W + 1;
    localparam int NUM_VERT   = 4;
    localparam int NUM_LANE   = 3 * NUM_VERT;
    localparam int DIV_FIRST  = 2;
    localparam int SQRT_FIRST = DIV_FIRST + DIV_STEPS;
    localparam int NUM_STAGES = SQRT_FIRST + SQRT_STEPS;

    localparam logic [LVL_W-1:0] LEVEL_RESET = LVL_W'(5);

    typedef logic signed [COORD_W-1:0] coord_t;

    typedef struct packed {
        logic [2:0]       face;
        logic [IDX_W-1:0] row;
        logic [IDX_W-1:0] col;
    } in_item_t;

    typedef struct packed {
        coord_t a_x;
        coord_t a_y;
        coord_t a_z;
        coord_t b_x;
        coord_t b_y;
        coord_t b_z;
        coord_t c_x;
        coord_t c_y;
        coord_t c_z;
        logic   mirrored;
        logic   last;
    } out_item_t;

    // One coordinate in flight: division remainder, quotient/radicand bits,
    // and the square root remainder and partial root.
    typedef struct packed {
        logic [REM_W-1:0]  rem_div;
        logic [F_W-1:0]    f;
        logic [RSQ_W-1:0]  rem_sq;
        logic [ROOT_W-1:0] root;
    } lane_t;

    typedef struct packed {
        logic [2:0]                      neg;
        logic                            two;
        logic [NUM_LANE-1:0][$bits(lane_t)-1:0] lane;
        logic [NUM_VERT-1:0][LEN_W-1:0]  len2;
    } stage_t;

    // One restoring division bit of m^2 * 2^(DIV_STEPS-1) / len2.
    function automatic lane_t div_step(lane_t l, logic [LEN_W-1:0] len, logic first);
        logic [REM_W:0] r;
        logic           ge;
        lane_t          o;
        o  = l;
        r  = first ? {1'b0, l.rem_div} : {l.rem_div, 1'b0};
        ge = (r >= (REM_W+1)'(len));
        if (ge) begin
            r = r - (REM_W+1)'(len);
        end
        o.rem_div = r[REM_W-1:0];
        o.f       = {l.f[F_W-2:0], ge};
        return o;
    endfunction

    // One digit of the integer square root, two radicand bits per step.
    function automatic lane_t sqrt_step(lane_t l);
        logic [RSQ_W+1:0] r;
        logic [RSQ_W+1:0] trial;
        lane_t            o;
        o     = l;
        r     = {l.rem_sq, l.f[F_W-1:F_W-2]};
        trial = (RSQ_W+2)'({l.root, 2'b01});
        if (r >= trial) begin
            r      = r - trial;
            o.root = {l.root[ROOT_W-2:0], 1'b1};
        end else begin
            o.root = {l.root[ROOT_W-2:0], 1'b0};
        end
        o.rem_sq = r[RSQ_W-1:0];
        o.f      = {l.f[F_W-3:0], 2'b00};
        return o;
    endfunction

endpackage

### sv/octahedron_sphere_triangle_gen_core.sv
// ----------------------------------------------------------------------------
// Octahedron sphere triangle generator core
// Turns one grid cell of one octahedron face into its triangles on the sphere.
// ----------------------------------------------------------------------------
// Each accepted cell beat gives one or two triangle beats: the upright
// triangle first and, when the row is not zero, the mirrored triangle with
// last set. Cells outside the face (col + row >= 2^div_level) are accepted
// and give nothing. Every vertex coordinate is the exact round-to-nearest of
// m * 2^14 / |v|, found as floor(m^2 * 2^30 / |v|^2) by a one-bit-per-stage
// restoring divider followed by a two-bit-per-stage square root, all twelve
// coordinates of a cell in parallel lanes. The pipeline is 49 stages and feeds
// the output register, which presents the first triangle of a cell; the
// mirrored one follows in the cycle after the upright beat is taken. A new
// cell enters every cycle while the result side keeps up; a cell with two
// triangles holds the output register for two beats, so the sustained rate
// is one cell per cycle for row-zero cells, and a two-triangle cell holds
// the pipeline until its mirrored beat is taken.
// The whole pipeline advances together and stalls only when the output
// register still holds an untaken beat. div_level is sampled when a cell is
// accepted and should be written only while the block is idle.
`include "octahedron_sphere_triangle_gen_core_defines.svh"

module octahedron_sphere_triangle_gen_core (
    input  logic                      aclk,
    input  logic                      aresetn,
    input  logic                      cfg_wr_en,
    input  logic [ostg_pkg::LVL_W-1:0] cfg_wr_data,
    input  logic                      s_valid,
    output logic                      s_ready,
    input  ostg_pkg::in_item_t        s_data,
    output logic                      m_valid,
    input  logic                      m_ready,
    output ostg_pkg::out_item_t       m_data
);
    import ostg_pkg::*;

    localparam int LAST = NUM_STAGES - 1;

    // Configuration register.
    logic [LVL_W-1:0] level_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            level_reg <= LEVEL_RESET;
        end else if (cfg_wr_en) begin
            level_reg <= cfg_wr_data;
        end
    end

    // Pipeline registers and control.
    stage_t                  pipe_reg  [NUM_STAGES];
    stage_t                  pipe_next [NUM_STAGES];
    logic [NUM_STAGES-1:0]   valid_reg;
    logic                    pipe_en;
    logic                    in_take;
    logic                    in_face;
    logic                    out_take;

    // Output register: four finished vertices and the beat phase.
    coord_t [NUM_VERT-1:0][2:0] vert_reg;
    coord_t [NUM_VERT-1:0][2:0] vert_d;
    logic                       two_reg;
    logic                       phase_reg;
    logic                       out_valid_reg;

    // The pipeline moves when its last stage is empty or can hand off.
    assign pipe_en = !valid_reg[LAST] || out_take;
    assign s_ready = pipe_en;
    assign in_take = s_valid && s_ready && in_face;

    // Entry stage: level saturation, face test, magnitudes and signs.
    always_comb begin
        logic [LVL_W-1:0]   lvl;
        logic [MAG_W:0]     n;
        logic [MAG_W:0]     sum;
        logic [MAG_W:0]     vi [NUM_VERT];
        logic [MAG_W:0]     vj [NUM_VERT];
        logic [MAG_W:0]     mx;
        logic [1:0]         xy;
        lane_t              ln;
        lvl = (level_reg > LVL_W'(MAX_LEVEL)) ? LVL_W'(MAX_LEVEL) : level_reg;
        n   = (MAG_W+1)'(1) << lvl;
        sum = (MAG_W+1)'(s_data.col) + (MAG_W+1)'(s_data.row);
        in_face = (sum < n);

        vi[0] = (MAG_W+1)'(s_data.col);
        vj[0] = (MAG_W+1)'(s_data.row);
        vi[1] = vi[0] + (MAG_W+1)'(1);
        vj[1] = vj[0];
        vi[2] = vi[0];
        vj[2] = vj[0] + (MAG_W+1)'(1);
        // Without a mirrored triangle the fourth vertex repeats the second.
        vi[3] = vi[1];
        vj[3] = (s_data.row != '0) ? vj[0] - (MAG_W+1)'(1) : vj[0];

        xy = s_data.face[1:0];
        pipe_next[0].neg[0] = (xy == 2'd1) || (xy == 2'd2);
        pipe_next[0].neg[1] = (xy == 2'd2) || (xy == 2'd3);
        pipe_next[0].neg[2] = s_data.face[2];
        pipe_next[0].two    = (s_data.row != '0);
        pipe_next[0].len2   = '0;
        ln = '0;
        for (int v = 0; v < NUM_VERT; v++) begin
            mx = n - vi[v] - vj[v];
            ln.rem_div = REM_W'(mx[MAG_W-1:0]);
            pipe_next[0].lane[3*v]   = ln;
            ln.rem_div = REM_W'(vi[v][MAG_W-1:0]);
            pipe_next[0].lane[3*v+1] = ln;
            ln.rem_div = REM_W'(vj[v][MAG_W-1:0]);
            pipe_next[0].lane[3*v+2] = ln;
        end
    end

    // Square stage: m^2 per lane and |v|^2 per vertex.
    always_comb begin
        logic [SQ_W-1:0]  sq [NUM_LANE];
        logic [SQ_W+1:0]  acc;
        lane_t            ln;
        pipe_next[1] = pipe_reg[0];
        for (int l = 0; l < NUM_LANE; l++) begin
            ln    = lane_t'(pipe_reg[0].lane[l]);
            sq[l] = ln.rem_div[MAG_W-1:0] * ln.rem_div[MAG_W-1:0];
            ln    = '0;
            ln.rem_div = REM_W'(sq[l]);
            pipe_next[1].lane[l] = ln;
        end
        for (int v = 0; v < NUM_VERT; v++) begin
            acc = (SQ_W+2)'(sq[3*v]) + (SQ_W+2)'(sq[3*v+1]) + (SQ_W+2)'(sq[3*v+2]);
            pipe_next[1].len2[v] = acc[LEN_W-1:0];
        end
    end

    // Division stages, then square root stages.
    for (genvar k = DIV_FIRST; k < NUM_STAGES; k++) begin : g_step
        always_comb begin
            pipe_next[k] = pipe_reg[k-1];
            for (int l = 0; l < NUM_LANE; l++) begin
                if (k < SQRT_FIRST) begin
                    pipe_next[k].lane[l] = div_step(lane_t'(pipe_reg[k-1].lane[l]),
                                                    pipe_reg[k-1].len2[l/3],
                                                    (k == DIV_FIRST));
                end else begin
                    pipe_next[k].lane[l] = sqrt_step(lane_t'(pipe_reg[k-1].lane[l]));
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= '0;
        end else if (pipe_en) begin
            valid_reg <= {valid_reg[NUM_STAGES-2:0], in_take};
        end
    end

    always_ff @(posedge aclk) begin
        if (pipe_en) begin
            for (int k = 0; k < NUM_STAGES; k++) begin
                pipe_reg[k] <= pipe_next[k];
            end
        end
    end

    // Output register. A cell leaves after its final triangle beat.
    assign out_take = !out_valid_reg || (m_ready && (phase_reg || !two_reg));

    always_comb begin
        lane_t             ln;
        logic [ROOT_W:0]   rnd;
        coord_t            q;
        coord_t [NUM_VERT-1:0][2:0] vert_next;
        for (int v = 0; v < NUM_VERT; v++) begin
            for (int c = 0; c < 3; c++) begin
                ln  = lane_t'(pipe_reg[LAST].lane[3*v+c]);
                rnd = (ROOT_W+1)'(ln.root) + (ROOT_W+1)'(1);
                q   = COORD_W'(rnd[ROOT_W:1]);
                vert_next[v][c] = pipe_reg[LAST].neg[c] ? -q : q;
            end
        end
        vert_d = vert_next;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
            phase_reg     <= 1'b0;
        end else if (out_take) begin
            out_valid_reg <= valid_reg[LAST];
            phase_reg     <= 1'b0;
        end else if (m_ready) begin
            phase_reg     <= 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (out_take) begin
            vert_reg <= vert_d;
            two_reg  <= pipe_reg[LAST].two;
        end
    end

    // Beat assembly: the mirrored triangle swaps in the fourth vertex.
    always_comb begin
        m_valid         = out_valid_reg;
        m_data.a_x      = vert_reg[0][0];
        m_data.a_y      = vert_reg[0][1];
        m_data.a_z      = vert_reg[0][2];
        m_data.b_x      = vert_reg[1][0];
        m_data.b_y      = vert_reg[1][1];
        m_data.b_z      = vert_reg[1][2];
        m_data.c_x      = phase_reg ? vert_reg[3][0] : vert_reg[2][0];
        m_data.c_y      = phase_reg ? vert_reg[3][1] : vert_reg[2][1];
        m_data.c_z      = phase_reg ? vert_reg[3][2] : vert_reg[2][2];
        m_data.mirrored = phase_reg;
        m_data.last     = phase_reg || !two_reg;
    end

    `OSTG_ASSERT_NOW(a_mirror_is_last, m_valid && m_data.mirrored, m_data.last,
        "mirrored triangle beat without last")
    `OSTG_ASSERT_NEXT(a_second_follows, m_valid && m_ready && !m_data.last,
        m_valid && m_data.mirrored, "upright beat of a two-triangle cell not followed")
    `OSTG_ASSERT_NEXT(a_stall_holds, !pipe_en, $stable(valid_reg),
        "pipeline valid bits moved during a stall")

endmodule

### bench/tb_octahedron_sphere_triangle_gen_core.sv
// ----------------------------------------------------------------------------
// Octahedron sphere triangle generator testbench
// Drives grid cells at the reset level, levels zero and seven and random levels,
// predicts each triangle on the unit sphere with an exact integer projection,
// and compares every beat.
module tb_octahedron_sphere_triangle_gen_core;
    timeunit 1ns;
    timeprecision 1ps;
    import ostg_pkg::*;

    // Holds the triangles still owed by the block and compares result beats.
    class triangle_scoreboard;
        out_item_t owed[$];
        int        errors;
        logic [LVL_W-1:0] level;

        // Largest q with (2q-1)^2 * len2 <= 4 * mag^2 * 4^FRAC_BITS.
        function automatic logic [15:0] sphere_coord(longint mag, longint len2);
            longint lo;
            longint hi;
            longint q;
            longint d;
            lo = 0;
            hi = longint'(1) << FRAC_BITS;
            if (mag == 0 || len2 == 0) begin
                return 16'd0;
            end
            while (lo < hi) begin
                q = lo + (hi - lo + 1) / 2;
                d = 2 * q - 1;
                if (d * d * len2 <= 4 * mag * mag * (longint'(1) << (2 * FRAC_BITS)))
                    lo = q;
                else
                    hi = q - 1;
            end
            return lo[15:0];
        endfunction

        function automatic void vertex(logic [2:0] face, longint n, longint i, longint j,
                                       output coord_t x, output coord_t y,
                                       output coord_t z);
            longint mx;
            longint len2;
            logic   nx;
            logic   ny;
            mx   = n - i - j;
            len2 = mx * mx + i * i + j * j;
            nx   = (face[1:0] == 2'd1) || (face[1:0] == 2'd2);
            ny   = (face[1:0] == 2'd2) || (face[1:0] == 2'd3);
            x = sphere_coord(mx, len2);
            y = sphere_coord(i, len2);
            z = sphere_coord(j, len2);
            if (nx) x = -x;
            if (ny) y = -y;
            if (face[2]) z = -z;
        endfunction

        function void note_cell(in_item_t c);
            longint    n;
            out_item_t t;
            n = longint'(1) << ((level > MAX_LEVEL) ? MAX_LEVEL : level);
            if (c.col + c.row >= n) return;
            vertex(c.face, n, c.col, c.row, t.a_x, t.a_y, t.a_z);
            vertex(c.face, n, c.col + 1, c.row, t.b_x, t.b_y, t.b_z);
            vertex(c.face, n, c.col, c.row + 1, t.c_x, t.c_y, t.c_z);
            t.mirrored = 1'b0;
            t.last     = (c.row == 0);
            owed = {owed, t};
            if (c.row == 0) return;
            vertex(c.face, n, c.col + 1, c.row - 1, t.c_x, t.c_y, t.c_z);
            t.mirrored = 1'b1;
            t.last     = 1'b1;
            owed = {owed, t};
        endfunction

        function void check_triangle(out_item_t got);
            out_item_t want;
            if (owed.size() == 0) begin
                errors++;
                if (errors <= 10) $display("unexpected triangle beat %h", got);
                return;
            end
            want = owed.pop_front();
            if (got !== want) begin
                errors++;
                if (errors <= 10)
                    $display("triangle mismatch: expected %h got %h", want, got);
            end
        endfunction
    endclass

    logic             aclk;
    logic             aresetn;
    logic             cfg_wr_en;
    logic [LVL_W-1:0] cfg_wr_data;
    logic             s_valid;
    logic             s_ready;
    in_item_t         s_data;
    logic             m_valid;
    logic             m_ready;
    out_item_t        m_data;

    triangle_scoreboard sb;
    int send_idle;   // percent of cycles the sender idles
    int recv_stall;  // percent of cycles the receiver stalls

    octahedron_sphere_triangle_gen_core dut (
        .aclk(aclk), .aresetn(aresetn),
        .cfg_wr_en(cfg_wr_en), .cfg_wr_data(cfg_wr_data),
        .s_valid(s_valid), .s_ready(s_ready), .s_data(s_data),
        .m_valid(m_valid), .m_ready(m_ready), .m_data(m_data)
    );

    initial begin
        aclk = 1'b0;
        forever #4 aclk = ~aclk;
    end

    // The receiver decides its ready for the next edge at each falling edge.
    always @(negedge aclk) begin
        m_ready <= ($urandom_range(99) >= recv_stall);
    end

    // Result beats are taken at the rising edge where valid meets ready.
    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready) sb.check_triangle(m_data);
    end

    // Presents one cell and holds it until the block takes it. Idle gaps
    // come first, so valid never drops between back-to-back beats; the
    // next cell, an idle gap or a drain replaces the accepted beat at the
    // following falling edge.
    task automatic send_cell(in_item_t c);
        while ($urandom_range(99) < send_idle) begin
            s_valid <= 1'b0;
            @(negedge aclk);
        end
        s_valid <= 1'b1;
        s_data  <= c;
        do @(posedge aclk); while (!s_ready);
        sb.note_cell(c);
        @(negedge aclk);
    endtask

    // Waits for every owed triangle plus the pipeline depth, so that cells
    // outside the face have also drained before the register is touched.
    task automatic drain();
        s_valid <= 1'b0;
        while (sb.owed.size() != 0) @(negedge aclk);
        repeat (NUM_STAGES + 10) @(negedge aclk);
    endtask

    task automatic set_level(logic [LVL_W-1:0] lvl);
        drain();
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= lvl;
        @(negedge aclk);
        cfg_wr_en   <= 1'b0;
        sb.level = lvl;
    endtask

    // Random cells: mostly inside the face at the current level, a few
    // anywhere in the full 7-bit range.
    task automatic random_cells(int count);
        in_item_t c;
        int       n;
        for (int k = 0; k < count; k++) begin
            n = 1 << sb.level;
            c.face = 3'($urandom_range(7));
            if ($urandom_range(9) == 0) begin
                c.row = 7'($urandom);
                c.col = 7'($urandom);
            end else begin
                c.row = 7'($urandom_range(n - 1));
                c.col = 7'($urandom_range(n - 1 - c.row));
            end
            send_cell(c);
        end
    endtask

    initial begin
        in_item_t c;
        sb = new();
        sb.level    = LEVEL_RESET;
        send_idle   = 0;
        recv_stall  = 0;
        aresetn     = 1'b0;
        cfg_wr_en   = 1'b0;
        cfg_wr_data = '0;
        s_valid     = 1'b0;
        s_data      = '0;
        m_ready     = 1'b0;
        repeat (9) @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        // Directed: every face at the reset level, with a row-zero cell, a
        // mirrored pair, the far corner, a cell just outside and the maximum
        // field values.
        for (int f = 0; f < 8; f++) begin
            c.face = 3'(f); c.row = 7'd0; c.col = 7'd0; send_cell(c);
            c.row = 7'd1; c.col = 7'(f); send_cell(c);
        end
        c.face = 3'd6; c.row = 7'd31; c.col = 7'd0;   send_cell(c);
        c.row = 7'd0;  c.col = 7'd31;                  send_cell(c);
        c.row = 7'd16; c.col = 7'd16;                  send_cell(c);
        c.row = 7'd127; c.col = 7'd127;                send_cell(c);
        // Level zero: a single cell per face; level seven: the widest grid.
        set_level(3'd0);
        c.face = 3'd5; c.row = 7'd0; c.col = 7'd0;     send_cell(c);
        c.row = 7'd0; c.col = 7'd1;                    send_cell(c);
        set_level(3'd7);
        c.face = 3'd7; c.row = 7'd127; c.col = 7'd0;   send_cell(c);
        c.row = 7'd64; c.col = 7'd63;                  send_cell(c);
        c.row = 7'd0;  c.col = 7'd127;                 send_cell(c);

        // Random phases over the idle mixes and several levels.
        for (int p = 0; p < 8; p++) begin
            unique case (p % 4)
                0: begin send_idle = 0;  recv_stall = 0;  end
                1: begin send_idle = 82; recv_stall = 0;  end
                2: begin send_idle = 0;  recv_stall = 82; end
                default: begin send_idle = 13; recv_stall = 13; end
            endcase
            set_level(3'($urandom_range(7)));
            random_cells(25);
            // Hold the sender until the block has caught up completely.
            drain();
            random_cells(25);
        end

        drain();
        if (sb.errors == 0 && sb.owed.size() == 0) begin
            $display("tb_octahedron_sphere_triangle_gen_core OK");
        end else begin
            $display("tb_octahedron_sphere_triangle_gen_core NOT OK");
        end
        $finish;
    end

    initial begin
        #5ms;
        $display("tb_octahedron_sphere_triangle_gen_core NOT OK");
        $finish;
    end
endmodule
